### sv/lobm_pkg.sv
package lobm_pkg;

    localparam int ORDERS_PER_SIDE_DEF = 32;
    localparam int PRICE_BITS_DEF      = 32;
    localparam logic [9:0] SLIP_RESET  = 10'd10;

    localparam logic [1:0] ST_TRADE  = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_DROP   = 2'd2;
    localparam logic [1:0] ST_IMPACT = 2'd3;

    typedef struct packed {
        logic load;
        logic adj;
        logic imp;
        logic scan;
        logic rd;
        logic fill;
        logic rest;
        logic emit;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic scan_busy;
        logic kind;
        logic can_fill;
        logic rest_ok;
    } t_sts;

endpackage

### sv/lobm_ctrl.sv
module lobm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  lobm_pkg::t_sts i_sts,
    output lobm_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_ADJ, S_IMP, S_SCAN, S_WAIT, S_DECIDE, S_FILL
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_pend, n_pend;
    logic   r_close, n_close;
    logic   r_final, n_final;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_close     = r_close;
        n_final     = r_final;
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADJ;
                end
            end
            S_ADJ: begin
                o_cmd.adj = 1'b1;
                n_pend    = 1'b0;
                n_state   = i_sts.kind ? S_IMP : S_SCAN;
            end
            S_IMP: begin
                o_cmd.imp = 1'b1;
                n_pend    = 1'b1;
                n_close   = 1'b0;
                n_final   = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.scan_busy) begin
                    if (!r_pend) begin
                        n_state = S_DECIDE;
                    end else if (w_out_free) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.close = r_close;
                        n_out_valid = 1'b1;
                        n_pend      = 1'b0;
                        n_state     = r_final ? S_IDLE : S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (i_sts.can_fill) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_FILL;
                end else if (i_sts.rest_ok) begin
                    o_cmd.rest = 1'b1;
                    n_pend     = 1'b1;
                    n_close    = 1'b1;
                    n_final    = 1'b1;
                    n_state    = S_SCAN;
                end else if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.close = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_pend     = 1'b1;
                n_close    = 1'b0;
                n_final    = 1'b0;
                n_state    = S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_close     <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_close     <= n_close;
            r_final     <= n_final;
        end
    end

endmodule

### sv/lobm_datapath.sv
module lobm_datapath #(
    parameter int ORDERS_PER_SIDE = lobm_pkg::ORDERS_PER_SIDE_DEF,
    parameter int PRICE_BITS      = lobm_pkg::PRICE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [9:0]     i_cfg_wr_data,
    input  logic           i_kind,
    input  logic           i_side,
    input  logic [31:0]    i_limit_price,
    input  logic [31:0]    i_quantity,
    input  logic [31:0]    i_user_id,
    input  lobm_pkg::t_cmd i_cmd,
    output lobm_pkg::t_sts o_sts,
    output logic [1:0]     o_status,
    output logic [31:0]    o_trade_price,
    output logic [31:0]    o_trade_qty,
    output logic           o_aggressor_side,
    output logic [31:0]    o_counterparty_user,
    output logic           o_last,
    output logic [31:0]    o_best_bid,
    output logic [31:0]    o_best_ask,
    output logic [31:0]    o_mid_price,
    output logic [31:0]    o_spread,
    output logic [31:0]    o_last_price
);

    localparam int N  = ORDERS_PER_SIDE;
    localparam int PB = PRICE_BITS;
    localparam int SW = $clog2(2 * N);
    localparam int CW = SW + 1;
    localparam int NW = $clog2(N + 1);
    localparam logic [63:0] PMAX = (64'd1 << PB) - 64'd1;
    localparam logic signed [63:0] OFF_MAX = 64'sd8589934591;
    localparam logic signed [63:0] OFF_MIN = -64'sd8589934592;

    function automatic logic [PB-1:0] clip(input logic signed [63:0] v);
        logic [PB-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if ($unsigned(v) > PMAX) begin
            res = PMAX[PB-1:0];
        end else begin
            res = v[PB-1:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] to32(input logic [PB-1:0] v);
        logic [PB+31:0] t;
        t = {32'd0, v};
        return t[31:0];
    endfunction

    logic [PB+15:0] r_mem_pa [2*N];
    logic [63:0]    r_mem_qu [2*N];

    logic [9:0]         r_slip;
    logic               r_kind, r_side;
    logic [31:0]        r_lp, r_qty, r_user;
    logic [PB-1:0]      r_price;
    logic [NW-1:0]      r_nfill;
    logic [15:0]        r_arr_cnt;
    logic signed [33:0] r_off;
    logic               r_applied;
    logic [PB-1:0]      r_ltp;
    logic [41:0]        r_shift;
    logic [2*N-1:0]     r_valid;

    logic               r_scan_on, r_rd_on;
    logic [CW-1:0]      r_scan_idx;
    logic [SW-1:0]      r_rd_idx;
    logic [PB+15:0]     r_pa_q;
    logic [63:0]        r_qu_q;

    logic               r_bb_found, r_ba_found, r_fb_found, r_fa_found;
    logic [PB-1:0]      r_bb_price, r_ba_price;
    logic [15:0]        r_bb_age, r_ba_age;
    logic [SW-1:0]      r_bb_slot, r_ba_slot, r_fb_slot, r_fa_slot;

    logic [1:0]         r_p_status;
    logic [PB-1:0]      r_p_price;
    logic [31:0]        r_p_qty, r_p_user;
    logic               r_p_last;

    logic [PB-1:0]      w_lp;
    logic [PB+31:0]     w_lp_ext;
    logic signed [63:0] w_lp_s, w_off_s, w_shift_s, w_off_new, w_base_s;
    logic [PB-1:0]      w_ltp_new;
    logic [PB-1:0]      w_sc_price;
    logic [15:0]        w_sc_age;
    logic               w_sc_valid, w_sc_bid;
    logic               w_opp_found;
    logic [PB-1:0]      w_opp_price;
    logic [SW-1:0]      w_opp_slot, w_free_slot;
    logic [31:0]        w_sq, w_fill, w_newq;
    logic [PB-1:0]      w_bid, w_ask;
    logic [PB:0]        w_sum;

    assign w_lp_ext  = {{PB{1'b0}}, r_lp};
    assign w_lp      = w_lp_ext[PB-1:0];
    assign w_lp_s    = $signed({32'd0, r_lp});
    assign w_off_s   = {{30{r_off[33]}}, r_off};
    assign w_shift_s = r_side ? $signed({22'd0, r_shift}) : -$signed({22'd0, r_shift});
    assign w_off_new = w_off_s + w_shift_s;
    assign w_base_s  = (r_ltp != '0) ? $signed(64'(r_ltp)) : w_lp_s;
    assign w_ltp_new = clip(w_base_s + w_shift_s);

    assign w_sc_price = r_pa_q[PB+15:16];
    assign w_sc_age   = r_arr_cnt - r_pa_q[15:0];
    assign w_sc_valid = r_valid[r_rd_idx];
    assign w_sc_bid   = (r_rd_idx < SW'(N));

    assign w_opp_found = r_side ? r_ba_found : r_bb_found;
    assign w_opp_price = r_side ? r_ba_price : r_bb_price;
    assign w_opp_slot  = r_side ? r_ba_slot : r_bb_slot;
    assign w_free_slot = r_side ? r_fb_slot : r_fa_slot;

    assign w_sq   = r_qu_q[63:32];
    assign w_fill = (r_qty < w_sq) ? r_qty : w_sq;
    assign w_newq = w_sq - w_fill;

    assign w_bid = r_bb_found ? r_bb_price : '0;
    assign w_ask = r_ba_found ? r_ba_price : '0;
    assign w_sum = {1'b0, w_bid} + {1'b0, w_ask};

    assign o_sts.scan_busy = r_scan_on || r_rd_on;
    assign o_sts.kind      = r_kind;
    assign o_sts.can_fill  = (r_qty != 32'd0) && (r_nfill < NW'(N)) && w_opp_found &&
                             (r_side ? (w_opp_price <= r_price) : (w_opp_price >= r_price));
    assign o_sts.rest_ok   = (r_qty != 32'd0) && (r_side ? r_fb_found : r_fa_found);

    // book state and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slip    <= lobm_pkg::SLIP_RESET;
            r_valid   <= '0;
            r_arr_cnt <= '0;
            r_off     <= '0;
            r_applied <= 1'b0;
            r_ltp     <= '0;
            r_scan_on <= 1'b0;
            r_rd_on   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slip <= i_cfg_wr_data;
            end
            r_rd_on <= r_scan_on;
            if (i_cmd.scan) begin
                r_scan_on <= 1'b1;
            end else if (r_scan_on && (r_scan_idx == CW'(2 * N - 1))) begin
                r_scan_on <= 1'b0;
            end
            if (i_cmd.imp) begin
                if (w_off_new > OFF_MAX) begin
                    r_off <= OFF_MAX[33:0];
                end else if (w_off_new < OFF_MIN) begin
                    r_off <= OFF_MIN[33:0];
                end else begin
                    r_off <= w_off_new[33:0];
                end
                r_applied <= 1'b1;
                r_valid   <= '0;
                r_ltp     <= w_ltp_new;
            end
            if (i_cmd.fill) begin
                r_ltp <= w_opp_price;
                if (w_newq == 32'd0) begin
                    r_valid[w_opp_slot] <= 1'b0;
                end
            end
            if (i_cmd.rest) begin
                r_valid[w_free_slot] <= 1'b1;
                r_arr_cnt            <= r_arr_cnt + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_side  <= i_side;
            r_lp    <= i_limit_price;
            r_qty   <= i_quantity;
            r_user  <= i_user_id;
            r_nfill <= '0;
        end
        if (i_cmd.adj) begin
            r_price <= r_applied ? clip(w_lp_s + w_off_s) : w_lp;
            r_shift <= r_qty * r_slip;
        end
        if (i_cmd.imp) begin
            r_p_status <= lobm_pkg::ST_IMPACT;
            r_p_price  <= w_ltp_new;
            r_p_qty    <= r_qty;
            r_p_user   <= r_user;
            r_p_last   <= 1'b1;
        end
        if (i_cmd.fill) begin
            r_qty      <= r_qty - w_fill;
            r_nfill    <= r_nfill + NW'(1);
            r_p_status <= lobm_pkg::ST_TRADE;
            r_p_price  <= w_opp_price;
            r_p_qty    <= w_fill;
            r_p_user   <= r_qu_q[31:0];
            r_p_last   <= 1'b0;
        end
        if (i_cmd.rest) begin
            r_qty <= '0;
        end
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.rest) begin
            r_mem_pa[w_free_slot] <= {r_price, r_arr_cnt};
        end
        if (r_scan_on) begin
            r_pa_q <= r_mem_pa[r_scan_idx[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rest) begin
            r_mem_qu[w_free_slot] <= {r_qty, r_user};
        end else if (i_cmd.fill) begin
            r_mem_qu[w_opp_slot] <= {w_newq, r_qu_q[31:0]};
        end
        if (i_cmd.rd) begin
            r_qu_q <= r_mem_qu[w_opp_slot];
        end
    end

    // best price and first free slot, one slot per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_scan_idx <= '0;
            r_bb_found <= 1'b0;
            r_ba_found <= 1'b0;
            r_fb_found <= 1'b0;
            r_fa_found <= 1'b0;
        end else begin
            if (r_scan_on) begin
                r_scan_idx <= r_scan_idx + CW'(1);
            end
            if (r_rd_on) begin
                if (w_sc_bid) begin
                    if (!w_sc_valid) begin
                        if (!r_fb_found) begin
                            r_fb_found <= 1'b1;
                            r_fb_slot  <= r_rd_idx;
                        end
                    end else if (!r_bb_found || (w_sc_price > r_bb_price) ||
                                 ((w_sc_price == r_bb_price) && (w_sc_age > r_bb_age))) begin
                        r_bb_found <= 1'b1;
                        r_bb_price <= w_sc_price;
                        r_bb_age   <= w_sc_age;
                        r_bb_slot  <= r_rd_idx;
                    end
                end else begin
                    if (!w_sc_valid) begin
                        if (!r_fa_found) begin
                            r_fa_found <= 1'b1;
                            r_fa_slot  <= r_rd_idx;
                        end
                    end else if (!r_ba_found || (w_sc_price < r_ba_price) ||
                                 ((w_sc_price == r_ba_price) && (w_sc_age > r_ba_age))) begin
                        r_ba_found <= 1'b1;
                        r_ba_price <= w_sc_price;
                        r_ba_age   <= w_sc_age;
                        r_ba_slot  <= r_rd_idx;
                    end
                end
            end
        end
        if (r_scan_on) begin
            r_rd_idx <= r_scan_idx[SW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.close) begin
                o_status            <= (r_qty != 32'd0) ? lobm_pkg::ST_DROP
                                                        : lobm_pkg::ST_DONE;
                o_trade_price       <= '0;
                o_trade_qty         <= '0;
                o_counterparty_user <= '0;
                o_last              <= 1'b1;
            end else begin
                o_status            <= r_p_status;
                o_trade_price       <= to32(r_p_price);
                o_trade_qty         <= r_p_qty;
                o_counterparty_user <= r_p_user;
                o_last              <= r_p_last;
            end
            o_aggressor_side <= r_side;
            o_best_bid       <= to32(w_bid);
            o_best_ask       <= to32(w_ask);
            if ((w_bid != '0) && (w_ask != '0)) begin
                o_mid_price <= to32(w_sum[PB:1]);
                o_spread    <= (w_ask >= w_bid) ? to32(w_ask - w_bid) : 32'd0;
            end else begin
                o_mid_price <= '0;
                o_spread    <= '0;
            end
            o_last_price <= to32(r_ltp);
        end
    end

endmodule

### sv/limit_order_book_matcher_unit.sv
// Price-time priority order book for one symbol, 2*ORDERS_PER_SIDE slots in
// on-chip memory. Every fill and every rest is followed by a full scan of the
// book, one slot per cycle, and that scan sets the timing; output stalls add
// to it. The next order can be accepted in the cycle after the last beat is
// issued. The block takes one order at a time; a finished result may wait
// in the output register while the next order is accepted. The user must
// write slippage_per_unit only while idle; the block does not enforce this.
module limit_order_book_matcher_unit #(
    parameter int ORDERS_PER_SIDE = lobm_pkg::ORDERS_PER_SIDE_DEF,
    parameter int PRICE_BITS      = lobm_pkg::PRICE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [9:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic        i_side,
    input  logic [31:0] i_limit_price,
    input  logic [31:0] i_quantity,
    input  logic [31:0] i_user_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_trade_qty,
    output logic        o_aggressor_side,
    output logic [31:0] o_counterparty_user,
    output logic        o_last,
    output logic [31:0] o_best_bid,
    output logic [31:0] o_best_ask,
    output logic [31:0] o_mid_price,
    output logic [31:0] o_spread,
    output logic [31:0] o_last_price
);

    lobm_pkg::t_cmd w_cmd;
    lobm_pkg::t_sts w_sts;

    lobm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lobm_datapath #(
        .ORDERS_PER_SIDE (ORDERS_PER_SIDE),
        .PRICE_BITS      (PRICE_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_kind              (i_kind),
        .i_side              (i_side),
        .i_limit_price       (i_limit_price),
        .i_quantity          (i_quantity),
        .i_user_id           (i_user_id),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_status            (o_status),
        .o_trade_price       (o_trade_price),
        .o_trade_qty         (o_trade_qty),
        .o_aggressor_side    (o_aggressor_side),
        .o_counterparty_user (o_counterparty_user),
        .o_last              (o_last),
        .o_best_bid          (o_best_bid),
        .o_best_ask          (o_best_ask),
        .o_mid_price         (o_mid_price),
        .o_spread            (o_spread),
        .o_last_price        (o_last_price)
    );

endmodule

### sv/lobm_checker.sv
module lobm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_trade_qty,
    input logic        o_last
);

    // a held result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // one order at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    a_fill_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == lobm_pkg::ST_TRADE) |-> !o_last)
        else $error("fill beat marked last");

    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == lobm_pkg::ST_DONE) || (o_status == lobm_pkg::ST_DROP))
        |-> o_last && (o_trade_qty == 32'd0))
        else $error("closing beat malformed");

    a_impact_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == lobm_pkg::ST_IMPACT) |-> o_last)
        else $error("impact beat not last");

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (.*);

### tb/tb_limit_order_book_matcher_unit.sv
module tb_limit_order_book_matcher_unit;

    localparam int SLOTS_PER_SIDE = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;
    localparam logic [31:0] PX_CENTER = 32'd5000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic        aggressor_side;
        logic [31:0] counterparty_user;
        logic        last;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
        logic [31:0] mid_price;
        logic [31:0] spread;
        logic [31:0] last_price;
    } t_fill_beat;

    function automatic string beat_str(t_fill_beat b);
        return $sformatf({"st=%0d px=%0d qty=%0d side=%0d cp=%0d last=%0d",
                          " bid=%0d ask=%0d mid=%0d spr=%0d lpx=%0d"},
                         b.status, b.trade_price, b.trade_qty, b.aggressor_side,
                         b.counterparty_user, b.last, b.best_bid, b.best_ask,
                         b.mid_price, b.spread, b.last_price);
    endfunction

    class book_scoreboard;
        t_fill_beat  fills_due[$];
        int          errors;
        logic [9:0]  slip;
        logic [31:0] s_price [2*SLOTS_PER_SIDE];
        logic [31:0] s_qty   [2*SLOTS_PER_SIDE];
        logic [31:0] s_user  [2*SLOTS_PER_SIDE];
        logic [15:0] s_arr   [2*SLOTS_PER_SIDE];
        bit          s_vld   [2*SLOTS_PER_SIDE];
        logic [15:0] arr_cnt;
        longint      offset;
        bit          applied;
        logic [31:0] last_px;

        function new();
            slip = lobm_pkg::SLIP_RESET;
            errors = 0;
            arr_cnt = 0;
            offset = 0;
            applied = 0;
            last_px = 0;
            foreach (s_vld[i]) begin
                s_vld[i] = 0;
                s_price[i] = 0;
                s_qty[i] = 0;
                s_user[i] = 0;
                s_arr[i] = 0;
            end
        endfunction

        function longint clip(longint v);
            if (v < 0) return 0;
            if (v > longint'(32'hFFFFFFFF)) return longint'(32'hFFFFFFFF);
            return v;
        endfunction

        function int best(bit bid_side);
            int base;
            int b;
            logic [15:0] b_age;
            logic [15:0] age;
            bit better;
            base = bid_side ? 0 : SLOTS_PER_SIDE;
            b = -1;
            b_age = 0;
            for (int i = base; i < base + SLOTS_PER_SIDE; i++) begin
                if (!s_vld[i]) continue;
                age = arr_cnt - s_arr[i];
                if (b < 0) better = 1;
                else if (s_price[i] != s_price[b])
                    better = bid_side ? (s_price[i] > s_price[b])
                                      : (s_price[i] < s_price[b]);
                else better = age > b_age;
                if (better) begin
                    b = i;
                    b_age = age;
                end
            end
            return b;
        endfunction

        function void push(logic [1:0] st, logic [31:0] px, logic [31:0] q, bit side,
                           logic [31:0] user, bit last);
            t_fill_beat e;
            int bi;
            int ai;
            logic [32:0] sum;
            bi = best(1);
            ai = best(0);
            e.status = st;
            e.trade_price = px;
            e.trade_qty = q;
            e.aggressor_side = side;
            e.counterparty_user = user;
            e.last = last;
            e.best_bid = bi >= 0 ? s_price[bi] : 0;
            e.best_ask = ai >= 0 ? s_price[ai] : 0;
            e.mid_price = 0;
            e.spread = 0;
            if (e.best_bid != 0 && e.best_ask != 0) begin
                sum = {1'b0, e.best_bid} + {1'b0, e.best_ask};
                e.mid_price = sum[32:1];
                e.spread = e.best_ask >= e.best_bid ? e.best_ask - e.best_bid : 0;
            end
            e.last_price = last_px;
            fills_due.insert(fills_due.size(), e);
        endfunction

        function void note_order(bit kind, bit side, logic [31:0] lp, logic [31:0] qty,
                                 logic [31:0] user);
            longint shift;
            longint off;
            longint base_px;
            longint price;
            logic [31:0] rem;
            logic [31:0] fill;
            logic [1:0] st;
            int n;
            int s;
            int fr;
            if (kind) begin
                shift = qty;
                shift = shift * longint'(slip);
                if (!side) shift = -shift;
                off = offset + shift;
                if (off > 64'sd8589934591) off = 64'sd8589934591;
                if (off < -64'sd8589934592) off = -64'sd8589934592;
                offset = off;
                applied = 1;
                foreach (s_vld[i]) s_vld[i] = 0;
                base_px = last_px != 0 ? last_px : lp;
                last_px = 32'(clip(base_px + shift));
                push(lobm_pkg::ST_IMPACT, last_px, qty, side, user, 1);
                return;
            end
            price = lp;
            if (applied) price = clip(price + offset);
            rem = qty;
            n = 0;
            st = lobm_pkg::ST_DONE;
            while (rem > 0 && n < SLOTS_PER_SIDE) begin
                s = best(!side);
                if (s < 0) break;
                if (side ? (longint'(s_price[s]) > price) : (longint'(s_price[s]) < price)) break;
                fill = rem < s_qty[s] ? rem : s_qty[s];
                last_px = s_price[s];
                rem -= fill;
                s_qty[s] -= fill;
                if (s_qty[s] == 0) s_vld[s] = 0;
                push(lobm_pkg::ST_TRADE, s_price[s], fill, side, s_user[s], 0);
                n++;
            end
            if (rem > 0) begin
                fr = -1;
                for (int i = (side ? 0 : SLOTS_PER_SIDE);
                     i < (side ? 0 : SLOTS_PER_SIDE) + SLOTS_PER_SIDE; i++) begin
                    if (!s_vld[i]) begin
                        fr = i;
                        break;
                    end
                end
                if (fr < 0) st = lobm_pkg::ST_DROP;
                else begin
                    s_vld[fr] = 1;
                    s_price[fr] = 32'(price);
                    s_qty[fr] = rem;
                    s_user[fr] = user;
                    s_arr[fr] = arr_cnt;
                    arr_cnt = arr_cnt + 16'd1;
                end
            end
            push(st, 0, 0, side, 0, 1);
        endfunction

        function void check_result(t_fill_beat got);
            t_fill_beat want;
            if (fills_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: %s", beat_str(got));
                return;
            end
            want = fills_due[0];
            fills_due.delete(0);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch\n  exp %s\n  got %s", beat_str(want), beat_str(got));
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [9:0]  cfg_wr_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        kind = 0;
    logic        side = 0;
    logic [31:0] limit_price = 0;
    logic [31:0] quantity = 0;
    logic [31:0] user_id = 0;
    logic        out_valid;
    logic        out_stall = 0;
    t_fill_beat  got;

    book_scoreboard sb = new();
    int in_idle_pct = 35;
    int out_idle_pct = 35;
    int quiet_cycles = 0;

    limit_order_book_matcher_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (cfg_wr_en),
        .i_cfg_wr_data       (cfg_wr_data),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_kind              (kind),
        .i_side              (side),
        .i_limit_price       (limit_price),
        .i_quantity          (quantity),
        .i_user_id           (user_id),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_status            (got.status),
        .o_trade_price       (got.trade_price),
        .o_trade_qty         (got.trade_qty),
        .o_aggressor_side    (got.aggressor_side),
        .o_counterparty_user (got.counterparty_user),
        .o_last              (got.last),
        .o_best_bid          (got.best_bid),
        .o_best_ask          (got.best_ask),
        .o_mid_price         (got.mid_price),
        .o_spread            (got.spread),
        .o_last_price        (got.last_price)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 0;
        end else begin
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall) sb.note_order(kind, side, limit_price, quantity, user_id);
            if (out_valid && !out_stall) sb.check_result(got);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send(bit k, bit s, logic [31:0] lp, logic [31:0] q, logic [31:0] u);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        kind <= k;
        side <= s;
        limit_price <= lp;
        quantity <= q;
        user_id <= u;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (sb.fills_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_slip(logic [9:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 0;
        sb.slip = v;
    endtask

    // bring the impact offset back to zero with unit slippage
    task automatic zero_offset();
        longint mag;
        write_slip(10'd1);
        while (sb.offset != 0) begin
            mag = sb.offset < 0 ? -sb.offset : sb.offset;
            if (mag > longint'(32'hFFFFFFFF)) mag = longint'(32'hFFFFFFFF);
            send(1, sb.offset < 0, 0, 32'(mag), $urandom);
            drain();
        end
    endtask

    task automatic random_order(int max_imp_qty);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            send(1, $urandom_range(1), $urandom, $urandom_range(0, max_imp_qty), $urandom);
        else if (r < 12)
            send(0, $urandom_range(1), $urandom, $urandom, $urandom);
        else if (r < 15)
            send(0, $urandom_range(1), PX_CENTER + $urandom_range(0, 400) - 200, 0, $urandom);
        else
            send(0, $urandom_range(1), PX_CENTER + $urandom_range(0, 400) - 200,
                 $urandom_range(1, 2000), $urandom);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed, reset slippage
        send(1, 1, 777, 3, 32'd9);
        send(0, 0, 1000, 10, 1);
        send(0, 0, 1000, 5, 2);
        send(0, 0, 1010, 7, 3);
        send(0, 1, 990, 4, 4);
        send(0, 1, 1005, 12, 5);
        send(0, 1, 1005, 0, 6);
        send(0, 0, 0, 20, 7);
        send(0, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(0, 0, 1500, 3, 0);
        send(1, 1, 0, 100, 8);
        send(0, 1, 2000, 6, 10);
        send(0, 0, 1900, 6, 11);

        write_slip(10'd1023);
        send(1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 12);
        send(1, 1, 0, 32'hFFFFFFFF, 13);
        send(0, 1, 0, 9, 14);
        send(0, 0, 32'hFFFFFFFF, 4, 15);
        send(1, 0, 5, 32'hFFFFFFFF, 16);
        send(1, 0, 5, 32'hFFFFFFFF, 17);
        send(1, 0, 5, 32'hFFFFFFFF, 18);
        send(0, 0, 32'hFFFFFFFF, 8, 19);
        send(0, 1, 32'hFFFFFFFF, 3, 20);

        // fill the ask side past capacity, then sweep it in one order
        zero_offset();
        send(1, 0, 0, 0, 21);
        for (int i = 0; i < SLOTS_PER_SIDE + 1; i++)
            send(0, 0, 32'd2000 + (i % 5), $urandom_range(1, 50), $urandom);
        send(0, 1, 32'd3000, 32'hFFFFFFF0, 22);
        for (int i = 0; i < SLOTS_PER_SIDE; i++)
            send(0, 1, 32'd1000 + (i % 3), $urandom_range(1, 50), $urandom);

        write_slip(10'd0);
        send(1, 1, PX_CENTER, 5, 23);
        in_idle_pct = 0;
        out_idle_pct = 0;
        repeat (60) random_order(50);
        in_idle_pct = 35;
        out_idle_pct = 35;
        repeat (60) random_order(50);

        write_slip(10'($urandom_range(1, 20)));
        repeat (90) random_order(50);
        write_slip(10'($urandom_range(0, 1023)));
        repeat (65) random_order(3);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.fills_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
